[hw/rtl/ryb_pkg.sv]
// Shared constants for the ray / box slab test pipeline.
// No dependencies.
`default_nettype none
package ryb_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned N_AXES          = 3;

  // configuration register indexes
  typedef enum logic {
    REG_T_NEAR = 1'b0,
    REG_T_FAR  = 1'b1
  } reg_idx_e;

endpackage
`default_nettype wire

[hw/rtl/ryb_recip.sv]
// Pipelined reciprocal 2^(2F)/d, one quotient bit per stage, saturated.
// Depends on ryb_pkg.
`default_nettype none
module ryb_recip import ryb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic signed [COORD_WIDTH-1:0] d_i,
  output logic signed [COORD_WIDTH-1:0]      recip_o
);
  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned QW = 2 * FRAC_BITS + 1;
  localparam int unsigned CW = (QW > W) ? QW : W;

  logic [W-1:0]  rem_q [QW];
  logic [W-1:0]  div_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic          neg_q [QW];
  logic signed [W-1:0] recip_q;

  logic [W-1:0] mag;
  assign mag = d_i[W-1] ? (~d_i + W'(1)) : d_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [W-1:0]  rem_in, div_in;
    logic [QW-1:0] quo_in;
    logic          neg_in;
    logic [W:0]    sh;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign div_in = mag;
      assign quo_in = '0;
      assign neg_in = d_i[W-1];
      // only the top dividend bit is set
      assign sh     = {rem_in, 1'b1};
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
      assign neg_in = neg_q[k-1];
      assign sh     = {rem_in, 1'b0};
    end
    assign ge = (sh >= {1'b0, div_in});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? W'(sh - {1'b0, div_in}) : sh[W-1:0];
        div_q[k] <= div_in;
        neg_q[k] <= neg_in;
        quo_q[k] <= quo_in | (ge ? (QW'(1) << (QW - 1 - k)) : '0);
      end
    end
  end

  logic [CW-1:0] q_ext, lim;
  logic [W-1:0]  q_w;
  assign q_ext = CW'(quo_q[QW-1]);
  assign lim   = CW'({1'b0, {(W-1){1'b1}}});
  assign q_w   = q_ext[W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (q_ext > lim) begin
        recip_q <= neg_q[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        recip_q <= neg_q[QW-1] ? -q_w : q_w;
      end
    end
  end

  assign recip_o = recip_q;

  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule
`default_nettype wire

[hw/rtl/ryb_dist.sv]
// Entry and exit distances of one slab: swap, subtract, multiply, shift, saturate.
// Depends on ryb_pkg. Three register stages.
`default_nettype none
module ryb_dist import ryb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [COORD_WIDTH-1:0] origin_i,
  input  wire logic signed [COORD_WIDTH-1:0] bmin_i,
  input  wire logic signed [COORD_WIDTH-1:0] bmax_i,
  input  wire logic signed [COORD_WIDTH-1:0] recip_i,
  output logic signed [COORD_WIDTH-1:0]      lo_o,
  output logic signed [COORD_WIDTH-1:0]      hi_o
);
  localparam int unsigned W = COORD_WIDTH;

  logic signed [W:0]   dlo_q, dhi_q;
  logic signed [W-1:0] rcp_q;
  logic signed [2*W:0] plo_q, phi_q;
  logic signed [W-1:0] lo_q, hi_q;
  logic signed [W-1:0] c_lo, c_hi;

  // negative reciprocal swaps entry and exit
  assign c_lo = recip_i[W-1] ? bmax_i : bmin_i;
  assign c_hi = recip_i[W-1] ? bmin_i : bmax_i;

  function automatic logic signed [W-1:0] sat_shift(input logic signed [2*W:0] p);
    logic signed [2*W:0] s;
    logic [W+1:0] top;
    s   = p >>> FRAC_BITS;
    top = s[2*W:W-1];
    if ((top == '0) || (top == '1)) begin
      return s[W-1:0];
    end
    return s[2*W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dlo_q <= {c_lo[W-1], c_lo} - {origin_i[W-1], origin_i};
      dhi_q <= {c_hi[W-1], c_hi} - {origin_i[W-1], origin_i};
      rcp_q <= recip_i;
      plo_q <= dlo_q * rcp_q;
      phi_q <= dhi_q * rcp_q;
      lo_q  <= sat_shift(plo_q);
      hi_q  <= sat_shift(phi_q);
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;
endmodule
`default_nettype wire

[hw/rtl/ray_box_slab_intersect_top.sv]
// Ray / axis-aligned box slab test, fully pipelined, with APB range registers.
// Depends on ryb_pkg, ryb_recip, ryb_dist.
//
//  channel   dir  handshake              content
//  s_axis    in   tvalid/tready          origin, dir, box_min, box_max (12 fields)
//  m_axis    out  tvalid/tready          hit
//  apb       in   psel/penable/pready    t_near (0x0), t_far (0x4, 0x8 if W>32)
//
// One item per cycle while m_axis is not stalled. The pipeline is the bit-per-stage
// reciprocal divider (2*FRAC_BITS+1 stages) plus saturate, 3 distance and
// 2 interval stages. Reset clears valid bits and loads t_near=0, t_far=max.
// A stalled output freezes the whole pipeline; s_axis_tready_o falls with it.
`default_nettype none
module ray_box_slab_intersect_top import ryb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  localparam int unsigned INW  = ((12 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned DW   = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int unsigned AW   = (COORD_WIDTH > 32) ? 4 : 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // origin_x,y,z, dir_x,y,z, box_min_x,y,z, box_max_x,y,z, zero pad
  input  wire logic [INW-1:0] s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  // hit, zero pad
  output logic [7:0]          m_axis_tdata_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [AW-1:0]  paddr,
  input  wire logic [DW-1:0]  pwdata,
  output logic [DW-1:0]       prdata,
  output logic                pready
);
  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned RL = 2 * FRAC_BITS + 2;
  localparam int unsigned L  = RL + 5;

  logic signed [W-1:0] t_near_q, t_far_q;
  reg_idx_e            idx;
  assign idx    = reg_idx_e'(paddr[AW-1]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_near_q <= '0;
      t_far_q  <= {1'b0, {(W-1){1'b1}}};
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_T_NEAR: t_near_q <= pwdata[W-1:0];
        REG_T_FAR:  t_far_q  <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_T_NEAR: prdata = DW'(unsigned'(t_near_q));
      REG_T_FAR:  prdata = DW'(unsigned'(t_far_q));
      default:    prdata = '0;
    endcase
  end

  logic [L-1:0] vld_q;
  logic         en;
  assign en              = !vld_q[L-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], s_axis_tvalid_i};
    end
  end

  // corner and origin delay lines matching the reciprocal latency
  logic [RL-1:0][N_AXES-1:0][W-1:0] org_q, mn_q, mx_q;
  logic signed [W-1:0] lo [N_AXES];
  logic signed [W-1:0] hi [N_AXES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < N_AXES; a++) begin
        org_q[0][a] <= s_axis_tdata_i[a*W +: W];
        mn_q[0][a]  <= s_axis_tdata_i[(6+a)*W +: W];
        mx_q[0][a]  <= s_axis_tdata_i[(9+a)*W +: W];
      end
      for (int s = 1; s < RL; s++) begin
        org_q[s] <= org_q[s-1];
        mn_q[s]  <= mn_q[s-1];
        mx_q[s]  <= mx_q[s-1];
      end
    end
  end

  for (genvar a = 0; a < N_AXES; a++) begin : g_axis
    logic signed [W-1:0] recip;
    ryb_recip #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_recip (
      .clk_i, .rst_ni, .en_i(en),
      .d_i(s_axis_tdata_i[(3+a)*W +: W]),
      .recip_o(recip)
    );
    ryb_dist #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_dist (
      .clk_i, .en_i(en),
      .origin_i(org_q[RL-1][a]),
      .bmin_i(mn_q[RL-1][a]),
      .bmax_i(mx_q[RL-1][a]),
      .recip_i(recip),
      .lo_o(lo[a]),
      .hi_o(hi[a])
    );
  end

  logic                miss_q, hit_q;
  logic signed [W-1:0] tmin_q, tmax_q, zlo_q, zhi_q;
  logic signed [W-1:0] tmin2, tmax2;
  logic                miss2;

  assign miss2 = (tmin_q > zhi_q) || (zlo_q > tmax_q);
  assign tmin2 = (zlo_q > tmin_q) ? zlo_q : tmin_q;
  assign tmax2 = (zhi_q < tmax_q) ? zhi_q : tmax_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      miss_q <= (lo[0] > hi[1]) || (lo[1] > hi[0]);
      tmin_q <= (lo[1] > lo[0]) ? lo[1] : lo[0];
      tmax_q <= (hi[1] < hi[0]) ? hi[1] : hi[0];
      zlo_q  <= lo[2];
      zhi_q  <= hi[2];
      hit_q  <= !miss_q && !miss2 && (tmin2 < t_far_q) && (tmax2 > t_near_q);
    end
  end

  assign m_axis_tvalid_o = vld_q[L-1];
  assign m_axis_tdata_o  = {7'b0, hit_q};
endmodule
`default_nettype wire

[hw/rtl/ryb_checker.sv]
// Port-level checks for the slab test top level, bound to it below.
// Depends on ryb_pkg.
`default_nettype none
module ryb_checker import ryb_pkg::*; #(
  parameter int unsigned INW = 48,
  parameter int unsigned DW  = 32,
  parameter int unsigned AW  = 3
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           s_axis_tvalid_i,
  input wire logic           s_axis_tready_o,
  input wire logic [INW-1:0] s_axis_tdata_i,
  input wire logic           m_axis_tvalid_o,
  input wire logic           m_axis_tready_i,
  input wire logic [7:0]     m_axis_tdata_o,
  input wire logic           psel,
  input wire logic           penable,
  input wire logic           pwrite,
  input wire logic [AW-1:0]  paddr,
  input wire logic [DW-1:0]  pwdata,
  input wire logic [DW-1:0]  prdata,
  input wire logic           pready
);
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o) else $error("valid dropped");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i)) else $error("ready rule");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:1] == 7'b0) else $error("pad bits set");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == '0 |=>
      (paddr != '0 || prdata[15:0] == $past(pwdata[15:0]))) else $error("readback");

  logic unused;
  assign unused = s_axis_tvalid_i ^ (^s_axis_tdata_i);
endmodule

bind ray_box_slab_intersect_top ryb_checker #(.INW(INW), .DW(DW), .AW(AW)) u_ryb_checker (.*);
`default_nettype wire
